/* sv/mwb_pkg.sv */
// Shared types, constants and helper function of the multi-hart write-back stage.
package mwb_pkg;

    localparam int HARTS         = 4;
    localparam int HART_W        = 2;
    localparam int REG_W         = 5;
    localparam int XLEN          = 32;
    localparam int RUNNING_HARTS = 4;

    // Load funct3 codes.
    localparam logic [2:0] LB  = 3'd0;
    localparam logic [2:0] LH  = 3'd1;
    localparam logic [2:0] LW  = 3'd2;
    localparam logic [2:0] LBU = 3'd4;
    localparam logic [2:0] LHU = 3'd5;

    // Bit positions in the command field.
    localparam int CMD_EX_BIT  = 0;
    localparam int CMD_MEM_BIT = 1;

    typedef struct packed {
        logic [1:0]        command;
        logic [HART_W-1:0] mem_hart;
        logic [REG_W-1:0]  mem_dest;
        logic              mem_no_dest;
        logic [XLEN-1:0]   mem_bytes;
        logic [1:0]        mem_offset;
        logic [2:0]        mem_size;
        logic [HART_W-1:0] ex_hart;
        logic [REG_W-1:0]  ex_dest;
        logic              ex_no_dest;
        logic              ex_is_ret;
        logic [XLEN-1:0]   ex_result;
    } wb_item_t;

    typedef struct packed {
        logic              unlock_valid;
        logic [REG_W-1:0]  dest_reg;
        logic [HART_W-1:0] dest_hart;
        logic              rf_write_enable;
        logic [XLEN-1:0]   rf_write_value;
        logic [HARTS-1:0]  full_mask;
        logic [HARTS-1:0]  exited_mask;
    } wb_result_t;

    // Harts that are not running start out as exited.
    function automatic logic [HARTS-1:0] exited_reset();
        logic [HARTS-1:0] m;
        m = '0;
        for (int h = 0; h < HARTS; h++) begin
            m[h] = (h >= RUNNING_HARTS);
        end
        return m;
    endfunction

endpackage

/* sv/mwb_load_extract.sv */
// Load data extraction: picks and extends the byte, half or word of a load.
module mwb_load_extract (
    input  logic [mwb_pkg::XLEN-1:0] bytes_in,
    input  logic [1:0]               offset,
    input  logic [2:0]               size,
    output logic [mwb_pkg::XLEN-1:0] value
);

    logic [7:0]  byte_sel;
    logic [15:0] half_sel;

    assign byte_sel = bytes_in[8*offset +: 8];
    assign half_sel = offset[1] ? bytes_in[31:16] : bytes_in[15:0];

    always_comb begin
        case (size)
            mwb_pkg::LB:  value = {{24{byte_sel[7]}}, byte_sel};
            mwb_pkg::LH:  value = {{16{half_sel[15]}}, half_sel};
            mwb_pkg::LW:  value = bytes_in;
            mwb_pkg::LBU: value = {24'd0, byte_sel};
            mwb_pkg::LHU: value = {16'd0, half_sel};
            default:      value = '0;
        endcase
    end

endmodule

/* sv/mwb_slot_file.sv */
// Per-hart pending slots: retirement of the lowest full hart and refill from both stages.
module mwb_slot_file (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  mwb_pkg::wb_item_t        item,
    input  logic [mwb_pkg::XLEN-1:0] loaded,
    output mwb_pkg::wb_result_t      result
);

    logic [mwb_pkg::HARTS-1:0]  slot_full_reg,   slot_full_next;
    logic [mwb_pkg::HARTS-1:0]  slot_exited_reg, slot_exited_next;
    logic [mwb_pkg::HARTS-1:0]  slot_no_dest_reg, slot_no_dest_next;
    logic [mwb_pkg::HARTS-1:0]  slot_ret_reg,    slot_ret_next;
    logic [mwb_pkg::REG_W-1:0]  slot_dest_reg    [mwb_pkg::HARTS];
    logic [mwb_pkg::REG_W-1:0]  slot_dest_next   [mwb_pkg::HARTS];
    logic [mwb_pkg::XLEN-1:0]   slot_value_reg   [mwb_pkg::HARTS];
    logic [mwb_pkg::XLEN-1:0]   slot_value_next  [mwb_pkg::HARTS];

    logic                       any_full;
    logic [mwb_pkg::HART_W-1:0] sel;
    logic                       mem_valid;
    logic                       ex_valid;

    assign mem_valid = item.command[mwb_pkg::CMD_MEM_BIT];
    assign ex_valid  = item.command[mwb_pkg::CMD_EX_BIT];
    assign any_full  = |slot_full_reg;

    always_comb begin
        // Priority pick: the lowest-numbered full hart, the last hart when none is full.
        sel = mwb_pkg::HART_W'(mwb_pkg::HARTS - 1);
        for (int h = mwb_pkg::HARTS - 1; h >= 0; h--) begin
            if (slot_full_reg[h]) begin
                sel = mwb_pkg::HART_W'(h);
            end
        end

        slot_full_next    = slot_full_reg;
        slot_exited_next  = slot_exited_reg;
        slot_no_dest_next = slot_no_dest_reg;
        slot_ret_next     = slot_ret_reg;
        slot_dest_next    = slot_dest_reg;
        slot_value_next   = slot_value_reg;

        // Retire first.
        if (any_full) begin
            slot_full_next[sel] = 1'b0;
            if (slot_ret_reg[sel] && (slot_value_reg[sel] == '0)) begin
                slot_exited_next[sel] = 1'b1;
            end
        end

        // Then refill. The execute beat overwrites the memory beat's fields on the
        // same hart, but the loaded word is written last and keeps the value field.
        if (mem_valid) begin
            slot_full_next[item.mem_hart]    = 1'b1;
            slot_dest_next[item.mem_hart]    = item.mem_dest;
            slot_no_dest_next[item.mem_hart] = item.mem_no_dest;
            slot_ret_next[item.mem_hart]     = 1'b0;
        end
        if (ex_valid) begin
            slot_full_next[item.ex_hart]    = 1'b1;
            slot_value_next[item.ex_hart]   = item.ex_result;
            slot_dest_next[item.ex_hart]    = item.ex_dest;
            slot_no_dest_next[item.ex_hart] = item.ex_no_dest;
            slot_ret_next[item.ex_hart]     = item.ex_is_ret;
        end
        if (mem_valid) begin
            slot_value_next[item.mem_hart] = loaded;
        end

        result.unlock_valid    = any_full && (slot_dest_reg[sel] != '0);
        result.dest_reg        = slot_dest_reg[sel];
        result.dest_hart       = sel;
        result.rf_write_enable = any_full && !slot_no_dest_reg[sel];
        result.rf_write_value  = result.rf_write_enable ? slot_value_reg[sel] : '0;
        result.full_mask       = slot_full_next;
        result.exited_mask     = slot_exited_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_full_reg   <= '0;
            slot_exited_reg <= mwb_pkg::exited_reset();
            for (int h = 0; h < mwb_pkg::HARTS; h++) begin
                slot_dest_reg[h] <= '0;
            end
        end else if (fire) begin
            slot_full_reg   <= slot_full_next;
            slot_exited_reg <= slot_exited_next;
            slot_dest_reg   <= slot_dest_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            slot_no_dest_reg <= slot_no_dest_next;
            slot_ret_reg     <= slot_ret_next;
            slot_value_reg   <= slot_value_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_write_from_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.rf_write_enable |-> slot_full_reg[result.dest_hart])
        else $error("register-file write issued from an empty slot");

    a_idle_holds_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(slot_full_reg) && $stable(slot_exited_reg))
        else $error("slot flags changed without a beat");

    a_exited_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (slot_exited_reg & $past(slot_exited_reg)) == $past(slot_exited_reg))
        else $error("an exited hart came back to life");
`endif

endmodule

/* sv/multihart_writeback_stage_core.sv */
// Top level of the multi-hart write-back stage: input register, slot logic, result register.
//
// The s_ channel carries one beat per cycle while s_ready is high; each beat
// bundles what the memory and execute stages hand over: s_command bit 1 marks
// a valid memory-stage instruction, bit 0 a valid execute-stage instruction,
// and a beat with neither still retires one slot if any is full. Each accepted
// beat yields exactly one result beat on the m_ channel: the retirement of the
// lowest-numbered full hart (register-file write, unlock, exit) plus the full
// and exited masks after the beat's refill has been applied.
//
// A beat accepted on s_ sits in the input register; when it fires, the slot
// logic updates the per-hart slots while the result moves into the result
// register, which presents it on m_. Throughput is one beat per cycle while
// m_ready is not held low, set by the single pass through the slot logic.
//
// If the receiver holds m_ready low, the result register keeps its beat and
// the slots and an occupied input register freeze; s_ready drops once the
// input register is also occupied. Reset (aresetn low, synchronous) empties
// both registers, clears all full flags and destinations, and marks harts at
// or above the running-hart count as exited.
module multihart_writeback_stage_core (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [mwb_pkg::HART_W-1:0] s_mem_hart,
    input  logic [mwb_pkg::REG_W-1:0]  s_mem_dest,
    input  logic                       s_mem_no_dest,
    input  logic [mwb_pkg::XLEN-1:0]   s_mem_bytes,
    input  logic [1:0]                 s_mem_offset,
    input  logic [2:0]                 s_mem_size,
    input  logic [mwb_pkg::HART_W-1:0] s_ex_hart,
    input  logic [mwb_pkg::REG_W-1:0]  s_ex_dest,
    input  logic                       s_ex_no_dest,
    input  logic                       s_ex_is_ret,
    input  logic [mwb_pkg::XLEN-1:0]   s_ex_result,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_unlock_valid,
    output logic [mwb_pkg::REG_W-1:0]  m_dest_reg,
    output logic [mwb_pkg::HART_W-1:0] m_dest_hart,
    output logic                       m_rf_write_enable,
    output logic [mwb_pkg::XLEN-1:0]   m_rf_write_value,
    output logic [mwb_pkg::HARTS-1:0]  m_full_mask,
    output logic [mwb_pkg::HARTS-1:0]  m_exited_mask
);

    logic                      in_valid_reg;
    mwb_pkg::wb_item_t         in_item_reg;
    logic                      out_valid_reg;
    mwb_pkg::wb_result_t       out_result_reg;

    logic                      out_free;
    logic                      fire;
    logic [mwb_pkg::XLEN-1:0]  loaded;
    mwb_pkg::wb_result_t       result;

    // The result register can take a new beat when it is empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    // A beat in the input register passes through the slot logic when the result
    // register can take it; only then do the slots change.
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command     <= s_command;
            in_item_reg.mem_hart    <= s_mem_hart;
            in_item_reg.mem_dest    <= s_mem_dest;
            in_item_reg.mem_no_dest <= s_mem_no_dest;
            in_item_reg.mem_bytes   <= s_mem_bytes;
            in_item_reg.mem_offset  <= s_mem_offset;
            in_item_reg.mem_size    <= s_mem_size;
            in_item_reg.ex_hart     <= s_ex_hart;
            in_item_reg.ex_dest     <= s_ex_dest;
            in_item_reg.ex_no_dest  <= s_ex_no_dest;
            in_item_reg.ex_is_ret   <= s_ex_is_ret;
            in_item_reg.ex_result   <= s_ex_result;
        end
    end

    mwb_load_extract u_load (
        .bytes_in (in_item_reg.mem_bytes),
        .offset   (in_item_reg.mem_offset),
        .size     (in_item_reg.mem_size),
        .value    (loaded)
    );

    mwb_slot_file u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .loaded  (loaded),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_unlock_valid    = out_result_reg.unlock_valid;
    assign m_dest_reg        = out_result_reg.dest_reg;
    assign m_dest_hart       = out_result_reg.dest_hart;
    assign m_rf_write_enable = out_result_reg.rf_write_enable;
    assign m_rf_write_value  = out_result_reg.rf_write_value;
    assign m_full_mask       = out_result_reg.full_mask;
    assign m_exited_mask     = out_result_reg.exited_mask;

endmodule
